/* hw/rtl/dpe_pkg.sv */
// Package for the door position estimator: operation codes, state codes,
// controller states and the command/status structs. No dependencies.
package dpe_pkg;

  localparam logic [1:0] OP_TICK   = 2'd0;
  localparam logic [1:0] OP_REPORT = 2'd1;
  localparam logic [1:0] OP_CMD    = 2'd2;

  localparam logic [2:0] DS_OPENING = 3'd0;
  localparam logic [2:0] DS_CLOSING = 3'd1;
  localparam logic [2:0] DS_OPEN    = 3'd2;
  localparam logic [2:0] DS_CLOSED  = 3'd3;
  localparam logic [2:0] DS_VENTING = 3'd4;
  localparam logic [2:0] DS_STOPPED = 3'd5;

  localparam logic [1:0] CMD_STOP   = 2'd0;
  localparam logic [1:0] CMD_TOGGLE = 2'd1;
  localparam logic [1:0] CMD_GOTO   = 2'd2;

  localparam logic [2:0] ACT_NONE    = 3'd0;
  localparam logic [2:0] ACT_STOP    = 3'd1;
  localparam logic [2:0] ACT_IMPULSE = 3'd2;
  localparam logic [2:0] ACT_OPEN    = 3'd3;
  localparam logic [2:0] ACT_CLOSE   = 3'd4;

  localparam logic [1:0] OPN_IDLE    = 2'd0;
  localparam logic [1:0] OPN_OPENING = 2'd1;
  localparam logic [1:0] OPN_CLOSING = 2'd2;

  localparam logic [1:0] REG_EST  = 2'd0;
  localparam logic [1:0] REG_CAL  = 2'd1;
  localparam logic [1:0] REG_OSEED = 2'd2;
  localparam logic [1:0] REG_CSEED = 2'd3;

  localparam int SEED_BITS = 18;
  localparam int PUBLISH_INTERVAL = 1000;
  localparam int SINCE_MAX = 1023;
  localparam int DEFAULT_SEED = 20000;
  localparam int TRAVEL_MIN = 2000;
  localparam int TRAVEL_MAX = 180000;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_APPLY,
    ST_BLEND,
    ST_OUT
  } dpe_state_t;

  // Controller to datapath.
  typedef struct packed {
    logic load;      // capture input word and do the simple update
    logic mul_go;    // form numerator for the division or the blend
    logic div_start; // start the divider
    logic apply;     // finish a tick with the quotient
    logic blend_go;  // finish a learned blend
    logic out_load;  // load the output register
  } dpe_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic need_div;   // tick with estimation in motion
    logic need_blend; // learn event that blends
    logic div_busy;
  } dpe_status_t;

endpackage

/* hw/rtl/door_position_estimator.sv */
// Top level of the door position estimator: controller plus datapath.
// Depends on dpe_pkg, dpe_ctrl, dpe_dp.
//
//   channel | signals                          | handshake
//   in      | op door_state command goal_pos.  | in_valid / in_ready
//   out     | drive_action ... close_time_ms   | out_valid / out_ready
//   cfg     | cfg_index cfg_data               | cfg_we, no wait
//
// One word at a time. Reports, commands and idle ticks pass through the IDLE,
// MUL and OUT states; a report that blends a learned duration adds a BLEND
// step. A tick in motion runs the divider, one quotient bit a cycle, in the
// DIV and APPLY states. Reset is synchronous.
// A stalled output holds the word until it is taken before the next is finished.
module door_position_estimator #(
  parameter int TIME_BITS     = 18,
  parameter int POSITION_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [17:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  op,
  input  logic [2:0]  door_state,
  input  logic [1:0]  command,
  input  logic [15:0] goal_position,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  drive_action,
  output logic [15:0] position_out,
  output logic [1:0]  operation_out,
  output logic        publish,
  output logic [17:0] open_time_ms,
  output logic [17:0] close_time_ms
);
  dpe_pkg::dpe_cmd_t    cmd;
  dpe_pkg::dpe_status_t status;

  dpe_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .status(status), .cmd(cmd)
  );

  dpe_dp #(.TIME_BITS(TIME_BITS), .POSITION_BITS(POSITION_BITS)) u_dp (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .op(op), .door_state(door_state), .command(command),
    .goal_position(goal_position), .cmd(cmd), .status(status),
    .out_valid(out_valid), .out_ready(out_ready), .drive_action(drive_action),
    .position_out(position_out), .operation_out(operation_out),
    .publish(publish), .open_time_ms(open_time_ms),
    .close_time_ms(close_time_ms)
  );
endmodule

/* hw/rtl/dpe_div.sv */
// Restoring divider, one quotient bit per cycle.
// Depends on nothing but its parameters.
module dpe_div #(
  parameter int NUM_BITS = 34,
  parameter int DEN_BITS = 18
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [NUM_BITS-1:0] num,
  input  logic [DEN_BITS-1:0] den,
  output logic                busy,
  output logic [NUM_BITS-1:0] quo
);
  localparam int CNT_BITS = $clog2(NUM_BITS + 1);

  logic [NUM_BITS-1:0] q;
  logic [DEN_BITS:0]   rem;
  logic [DEN_BITS-1:0] d;
  logic [CNT_BITS-1:0] cnt;
  logic [DEN_BITS:0]   trial;

  assign trial = {rem[DEN_BITS-1:0], q[NUM_BITS-1]};
  assign quo   = q;

  // Shift-subtract iteration.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CNT_BITS'(NUM_BITS);
      q    <= num;
      rem  <= '0;
      d    <= den;
    end else if (busy) begin
      if (trial >= {1'b0, d}) begin
        rem <= trial - {1'b0, d};
        q   <= {q[NUM_BITS-2:0], 1'b1};
      end else begin
        rem <= trial;
        q   <= {q[NUM_BITS-2:0], 1'b0};
      end
      cnt <= cnt - 1'b1;
      if (cnt == CNT_BITS'(1)) begin
        busy <= 1'b0;
      end
    end
  end
endmodule

/* hw/rtl/dpe_ctrl.sv */
// Controller state machine for the door position estimator.
// Depends on dpe_pkg.
module dpe_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                out_valid,
  input  logic                out_ready,
  input  dpe_pkg::dpe_status_t status,
  output dpe_pkg::dpe_cmd_t   cmd
);
  dpe_pkg::dpe_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dpe_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Sequence one word at a time; the output register frees once taken.
  always_comb begin
    state_next = state;
    cmd = '0;
    in_ready = 1'b0;
    case (state)
      dpe_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          state_next = dpe_pkg::ST_MUL;
        end
      end
      dpe_pkg::ST_MUL: begin
        if (status.need_div) begin
          cmd.mul_go = 1'b1;
          state_next = dpe_pkg::ST_DIV;
        end else if (status.need_blend) begin
          cmd.mul_go = 1'b1;
          state_next = dpe_pkg::ST_BLEND;
        end else begin
          state_next = dpe_pkg::ST_OUT;
        end
      end
      dpe_pkg::ST_DIV: begin
        cmd.div_start = 1'b1;
        state_next = dpe_pkg::ST_APPLY;
      end
      dpe_pkg::ST_APPLY: begin
        if (!status.div_busy) begin
          cmd.apply = 1'b1;
          state_next = dpe_pkg::ST_OUT;
        end
      end
      dpe_pkg::ST_BLEND: begin
        if (!status.div_busy) begin
          cmd.blend_go = 1'b1;
          state_next = dpe_pkg::ST_OUT;
        end else begin
          state_next = dpe_pkg::ST_BLEND;
        end
      end
      dpe_pkg::ST_OUT: begin
        if (!out_valid || out_ready) begin
          cmd.out_load = 1'b1;
          state_next = dpe_pkg::ST_IDLE;
        end
      end
      default: state_next = dpe_pkg::ST_IDLE;
    endcase
  end
endmodule

/* hw/rtl/dpe_dp.sv */
// Datapath of the door position estimator: state registers, the tick
// divider and the output register. Depends on dpe_pkg and dpe_div.
module dpe_dp #(
  parameter int TIME_BITS     = 18,
  parameter int POSITION_BITS = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [1:0]                 cfg_index,
  input  logic [17:0]                cfg_data,
  input  logic [1:0]                 op,
  input  logic [2:0]                 door_state,
  input  logic [1:0]                 command,
  input  logic [15:0]                goal_position,
  input  dpe_pkg::dpe_cmd_t          cmd,
  output dpe_pkg::dpe_status_t       status,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [2:0]                 drive_action,
  output logic [15:0]                position_out,
  output logic [1:0]                 operation_out,
  output logic                       publish,
  output logic [17:0]                open_time_ms,
  output logic [17:0]                close_time_ms
);
  localparam int PB = POSITION_BITS;
  localparam int TB = TIME_BITS;
  localparam int NB = TB + PB;
  localparam logic [PB-1:0] POS_FULL = {PB{1'b1}};
  localparam logic [PB-1:0] POS_TENTH = PB'((2 ** PB - 1) / 10);
  localparam logic [TB-1:0] TIME_MAX = {TB{1'b1}};
  localparam logic [TB+1:0] DEF_SEED = (TB + 2)'(dpe_pkg::DEFAULT_SEED);
  // ceil(2^26 / 10); exact for sums below 2^26 / 6, which covers
  // 3 * 180000 + 7 * (2^18 - 1).
  localparam logic [22:0] TENTH_RECIP = 23'd6710887;

  // Configuration.
  logic est_en, auto_cal;
  logic [17:0] open_seed, close_seed;

  // Estimator state.
  logic [PB-1:0] cur_pos, start_pos, target_val;
  logic [1:0]    cur_op;
  logic          target_vld;
  logic [TB-1:0] elapsed;
  logic [9:0]    since_pub;
  logic [TB+1:0] open_dur, close_dur;
  logic          open_lrn, close_lrn;
  logic [2:0]    last_ds;

  // Per-word working registers.
  logic [2:0]    w_action;
  logic          w_pub;
  logic          w_div, w_blend, w_blend_open;
  logic [NB-1:0] num;
  logic [TB+1:0] den;
  logic          den_zero;
  logic          div_busy;
  logic [NB-1:0] quo;
  logic [NB+1:0] quo_w;
  logic [44:0]   blend_prod;

  // Values for the simple update.
  logic [2:0]    ds;
  logic [TB-1:0] el_inc;
  logic [9:0]    sp_inc;
  logic [TB+1:0] cur_dur;
  logic          learn_ok;
  logic [PB+4:0] start20;
  logic [PB+5:0] full19;

  assign ds      = (door_state > 3'd5) ? dpe_pkg::DS_STOPPED : door_state;
  assign el_inc  = (elapsed < TIME_MAX) ? elapsed + 1'b1 : elapsed;
  assign sp_inc  = (since_pub < 10'(dpe_pkg::SINCE_MAX)) ? since_pub + 1'b1 : since_pub;
  assign cur_dur = (cur_op == dpe_pkg::OPN_OPENING) ? open_dur : close_dur;
  assign start20 = (PB + 5)'(start_pos) * (PB + 5)'(20);
  assign full19  = (PB + 6)'(POS_FULL) * (PB + 6)'(19);
  assign learn_ok = auto_cal && (elapsed >= TB'(dpe_pkg::TRAVEL_MIN)) &&
                    ((TB + 1)'(elapsed) <= (TB + 1)'(dpe_pkg::TRAVEL_MAX));

  assign status.need_div   = w_div;
  assign status.need_blend = w_blend;
  assign status.div_busy   = div_busy;

  dpe_div #(.NUM_BITS(NB + 2), .DEN_BITS(TB + 2)) u_div (
    .clk  (clk),
    .rst  (rst),
    .start(cmd.div_start),
    .num  ({2'b00, num}),
    .den  (den),
    .busy (div_busy),
    .quo  (quo_w)
  );
  assign quo = quo_w[NB-1:0];

  // Blend over ten by reciprocal multiplication.
  assign blend_prod = 45'(num[21:0]) * 45'(TENTH_RECIP);

  // Tick completion values.
  logic [PB-1:0] frac;
  logic [PB:0]   up_sum;
  logic [PB-1:0] new_pos;
  logic          reached;
  always_comb begin
    if (den_zero || (quo_w > (NB + 2)'(POS_FULL))) begin
      frac = POS_FULL;
    end else begin
      frac = quo[PB-1:0];
    end
    up_sum = {1'b0, start_pos} + {1'b0, frac};
    if (cur_op == dpe_pkg::OPN_OPENING) begin
      new_pos = up_sum[PB] ? POS_FULL : up_sum[PB-1:0];
    end else begin
      new_pos = (start_pos > frac) ? start_pos - frac : '0;
    end
    reached = target_vld &&
      (((cur_op == dpe_pkg::OPN_OPENING) && (new_pos >= target_val)) ||
       ((cur_op == dpe_pkg::OPN_CLOSING) && (new_pos <= target_val)));
  end

  function automatic logic [TB+1:0] seed_of(input logic [17:0] s, input logic cal);
    if (s == '0 && cal) begin
      return DEF_SEED;
    end
    return (TB + 2)'(s);
  endfunction

  // Main state update.
  always_ff @(posedge clk) begin
    if (rst) begin
      est_en <= 1'b1; auto_cal <= 1'b0;
      open_seed <= '0; close_seed <= '0;
      cur_pos <= '0; start_pos <= '0; target_val <= '0;
      cur_op <= dpe_pkg::OPN_IDLE; target_vld <= 1'b0;
      elapsed <= '0; since_pub <= '0;
      open_dur <= '0; close_dur <= '0;
      open_lrn <= 1'b0; close_lrn <= 1'b0;
      last_ds <= dpe_pkg::DS_STOPPED;
      w_div <= 1'b0; w_blend <= 1'b0; w_blend_open <= 1'b0;
      w_action <= '0; w_pub <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // The user makes configuration writes only while idle; the block does not enforce it.
      if (cfg_we) begin
        case (cfg_index)
          dpe_pkg::REG_EST: est_en <= cfg_data[0];
          dpe_pkg::REG_CAL: begin
            auto_cal <= cfg_data[0];
            if (!open_lrn) open_dur <= seed_of(open_seed, cfg_data[0]);
            if (!close_lrn) close_dur <= seed_of(close_seed, cfg_data[0]);
          end
          dpe_pkg::REG_OSEED: begin
            open_seed <= cfg_data;
            open_dur <= seed_of(cfg_data, auto_cal);
            open_lrn <= 1'b0;
          end
          dpe_pkg::REG_CSEED: begin
            close_seed <= cfg_data;
            close_dur <= seed_of(cfg_data, auto_cal);
            close_lrn <= 1'b0;
          end
          default: ;
        endcase
      end

      // Word capture and the updates that need no division.
      if (cmd.load) begin
        w_action <= dpe_pkg::ACT_NONE;
        w_pub <= 1'b0;
        w_div <= 1'b0;
        w_blend <= 1'b0;
        case (op)
          dpe_pkg::OP_TICK: begin
            elapsed <= el_inc;
            since_pub <= sp_inc;
            w_div <= est_en && (cur_op != dpe_pkg::OPN_IDLE);
          end
          dpe_pkg::OP_REPORT: begin
            w_pub <= (ds != last_ds) ||
                     (ds != dpe_pkg::DS_OPENING && ds != dpe_pkg::DS_CLOSING) ||
                     (ds == dpe_pkg::DS_OPENING && cur_op != dpe_pkg::OPN_OPENING) ||
                     (ds == dpe_pkg::DS_CLOSING && cur_op != dpe_pkg::OPN_CLOSING);
            if ((ds != last_ds) ||
                (ds != dpe_pkg::DS_OPENING && ds != dpe_pkg::DS_CLOSING) ||
                (ds == dpe_pkg::DS_OPENING && cur_op != dpe_pkg::OPN_OPENING) ||
                (ds == dpe_pkg::DS_CLOSING && cur_op != dpe_pkg::OPN_CLOSING)) begin
              since_pub <= '0;
            end
            last_ds <= ds;
            case (ds)
              dpe_pkg::DS_OPENING: begin
                if (cur_op != dpe_pkg::OPN_OPENING) begin
                  elapsed <= '0; start_pos <= cur_pos;
                end
                cur_op <= dpe_pkg::OPN_OPENING;
              end
              dpe_pkg::DS_CLOSING: begin
                if (cur_op != dpe_pkg::OPN_CLOSING) begin
                  elapsed <= '0; start_pos <= cur_pos;
                end
                cur_op <= dpe_pkg::OPN_CLOSING;
              end
              dpe_pkg::DS_OPEN: begin
                if (cur_op == dpe_pkg::OPN_OPENING && learn_ok &&
                    !((PB + 5)'(start20) > (PB + 5)'(POS_FULL))) begin
                  if (open_lrn) begin
                    w_blend <= 1'b1; w_blend_open <= 1'b1;
                  end else begin
                    open_dur <= (TB + 2)'(elapsed);
                  end
                  open_lrn <= 1'b1;
                end
                cur_op <= dpe_pkg::OPN_IDLE;
                cur_pos <= POS_FULL;
                target_vld <= 1'b0;
              end
              dpe_pkg::DS_CLOSED: begin
                if (cur_op == dpe_pkg::OPN_CLOSING && learn_ok &&
                    !((PB + 6)'(start20) < full19)) begin
                  if (close_lrn) begin
                    w_blend <= 1'b1; w_blend_open <= 1'b0;
                  end else begin
                    close_dur <= (TB + 2)'(elapsed);
                  end
                  close_lrn <= 1'b1;
                end
                cur_op <= dpe_pkg::OPN_IDLE;
                cur_pos <= '0;
                target_vld <= 1'b0;
              end
              default: begin
                cur_op <= dpe_pkg::OPN_IDLE;
                if (!est_en) cur_pos <= POS_TENTH;
                target_vld <= 1'b0;
              end
            endcase
          end
          dpe_pkg::OP_CMD: begin
            case (command)
              dpe_pkg::CMD_STOP: begin
                target_vld <= 1'b0; w_action <= dpe_pkg::ACT_STOP;
              end
              dpe_pkg::CMD_TOGGLE: w_action <= dpe_pkg::ACT_IMPULSE;
              dpe_pkg::CMD_GOTO: begin
                if ({1'b0, goal_position} >= 17'(POS_FULL)) begin
                  target_vld <= 1'b0; w_action <= dpe_pkg::ACT_OPEN;
                end else if (goal_position == '0) begin
                  target_vld <= 1'b0; w_action <= dpe_pkg::ACT_CLOSE;
                end else if (est_en && (PB'(goal_position) > cur_pos)) begin
                  target_vld <= 1'b1; target_val <= PB'(goal_position);
                  w_action <= dpe_pkg::ACT_OPEN;
                end else if (est_en && (PB'(goal_position) < cur_pos)) begin
                  target_vld <= 1'b1; target_val <= PB'(goal_position);
                  w_action <= dpe_pkg::ACT_CLOSE;
                end
              end
              default: ;
            endcase
          end
          default: ;
        endcase
      end

      // Numerator: elapsed * full scale, or the blend sum.
      if (cmd.mul_go) begin
        if (w_div) begin
          num <= NB'(elapsed) * NB'(POS_FULL);
          den <= cur_dur;
          den_zero <= (cur_dur == '0);
        end else begin
          num <= NB'(elapsed) * NB'(3) +
                 NB'(w_blend_open ? open_dur : close_dur) * NB'(7);
        end
      end

      // Tick completion with the quotient.
      if (cmd.apply) begin
        cur_pos <= new_pos;
        if (reached) begin
          target_vld <= 1'b0;
          w_action <= dpe_pkg::ACT_STOP;
          w_pub <= 1'b1;
        end else if (since_pub >= 10'(dpe_pkg::PUBLISH_INTERVAL)) begin
          since_pub <= '0;
          w_pub <= 1'b1;
        end
      end

      if (cmd.blend_go) begin
        if (w_blend_open) open_dur <= (TB + 2)'(blend_prod[44:26]);
        else close_dur <= (TB + 2)'(blend_prod[44:26]);
      end

      // Output register.
      if (cmd.out_load) begin
        out_valid <= 1'b1;
        drive_action <= w_action;
        position_out <= 16'(cur_pos);
        operation_out <= cur_op;
        publish <= w_pub;
        open_time_ms <= open_dur[17:0];
        close_time_ms <= close_dur[17:0];
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end
endmodule
